FILE: design/mks_pkg.sv
// shared types, register map and key map for the matrix keypad scanner
// no dependencies; imported by every scanner module
`timescale 1ns / 1ps
`default_nettype none

package mks_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned WAIT_W = 16;

  // register indexes, taken from paddr[4:2]
  localparam logic [2:0] REG_ENABLE       = 3'd0;
  localparam logic [2:0] REG_SCAN_PERIOD  = 3'd1;
  localparam logic [2:0] REG_SETTLE_TIME  = 3'd2;
  localparam logic [2:0] REG_RELEASE_POLL = 3'd3;
  localparam logic [2:0] REG_COLUMN_GAP   = 3'd4;

  typedef struct packed {
    logic              enable;
    logic [WAIT_W-1:0] scan_period;
    logic [WAIT_W-1:0] settle_time;
    logic [WAIT_W-1:0] release_poll;
    logic [WAIT_W-1:0] column_gap;
  } cfg_t;

  typedef struct packed {
    logic [3:0] column_drive;
    logic       key_valid;
    logic [6:0] key_code;
    logic [3:0] key_index;
    logic       scan_busy;
  } result_t;

  // ascii map, row-major: 123A / 456B / 789C / *0#D
  function automatic logic [6:0] key_char(input logic [3:0] idx);
    logic [6:0] c;
    case (idx)
      4'd0:    c = 7'h31;
      4'd1:    c = 7'h32;
      4'd2:    c = 7'h33;
      4'd3:    c = 7'h41;
      4'd4:    c = 7'h34;
      4'd5:    c = 7'h35;
      4'd6:    c = 7'h36;
      4'd7:    c = 7'h42;
      4'd8:    c = 7'h37;
      4'd9:    c = 7'h38;
      4'd10:   c = 7'h39;
      4'd11:   c = 7'h43;
      4'd12:   c = 7'h2A;
      4'd13:   c = 7'h30;
      4'd14:   c = 7'h23;
      default: c = 7'h44;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/mks_if.sv
// valid/ready channel interfaces for row samples and scan reports
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface mks_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] row_levels;

  modport source (output valid, output row_levels, input ready);
  modport sink (input valid, input row_levels, output ready);
endinterface

interface mks_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] column_drive;
  logic       key_valid;
  logic [6:0] key_code;
  logic [3:0] key_index;
  logic       scan_busy;

  modport source (output valid, output column_drive, output key_valid, output key_code,
                  output key_index, output scan_busy, input ready);
  modport sink (input valid, input column_drive, input key_valid, input key_code,
                input key_index, input scan_busy, output ready);
endinterface

`default_nettype wire

FILE: design/mks_regs.sv
// apb-style configuration register file for the keypad scanner
// depends on mks_pkg
`timescale 1ns / 1ps
`default_nettype none

module mks_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mks_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mks_pkg::DATA_W-1:0] pwdata,
  output logic      [mks_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output mks_pkg::cfg_t                   cfg
);
  import mks_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable       <= 1'b0;
      cfg.scan_period  <= 16'd100;
      cfg.settle_time  <= 16'd10;
      cfg.release_poll <= 16'd20;
      cfg.column_gap   <= 16'd10;
    end else if (wr) begin
      case (idx)
        REG_ENABLE:       cfg.enable       <= pwdata[0];
        REG_SCAN_PERIOD:  cfg.scan_period  <= pwdata[WAIT_W-1:0];
        REG_SETTLE_TIME:  cfg.settle_time  <= pwdata[WAIT_W-1:0];
        REG_RELEASE_POLL: cfg.release_poll <= pwdata[WAIT_W-1:0];
        REG_COLUMN_GAP:   cfg.column_gap   <= pwdata[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLE:       prdata = {{(DATA_W-1){1'b0}}, cfg.enable};
      REG_SCAN_PERIOD:  prdata = {{(DATA_W-WAIT_W){1'b0}}, cfg.scan_period};
      REG_SETTLE_TIME:  prdata = {{(DATA_W-WAIT_W){1'b0}}, cfg.settle_time};
      REG_RELEASE_POLL: prdata = {{(DATA_W-WAIT_W){1'b0}}, cfg.release_poll};
      REG_COLUMN_GAP:   prdata = {{(DATA_W-WAIT_W){1'b0}}, cfg.column_gap};
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/mks_core.sv
// scan state machine: one tick step per enabled cycle, result is combinational
// depends on mks_pkg
`timescale 1ns / 1ps
`default_nettype none

module mks_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [3:0]      rows,
  input  wire mks_pkg::cfg_t   cfg,
  output mks_pkg::result_t     res
);
  import mks_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SETTLE,
    PH_RELEASE,
    PH_GAP
  } phase_t;

  phase_t            phase, phase_next;
  logic [1:0]        column, column_next;
  logic [1:0]        row, row_next;
  logic [WAIT_W-1:0] wait_count, wait_count_next;
  logic [WAIT_W-1:0] period_count, period_count_next;
  logic              pending, pending_next;
  logic [3:0]        drive, drive_next;

  logic [WAIT_W-1:0] period_inc, period_eff, wait_dec;
  logic              trigger, wait_done, do_check, do_end, do_start, hit;
  logic [3:0]        check_mask, low_rows;
  logic [1:0]        hit_row, start_col;
  logic [3:0]        key_idx;

  always_comb begin
    phase_next        = phase;
    column_next       = column;
    row_next          = row;
    wait_count_next   = wait_count;
    period_count_next = period_count;
    pending_next      = pending;
    drive_next        = drive;
    trigger           = 1'b0;
    do_check          = 1'b0;
    do_end            = 1'b0;
    do_start          = 1'b0;
    check_mask        = 4'b1111;
    start_col         = 2'd0;
    hit               = 1'b0;
    hit_row           = 2'd0;
    key_idx           = 4'd0;
    res.key_valid     = 1'b0;
    res.key_code      = 7'd0;
    res.key_index     = 4'd0;

    // period counter, zero period acts like one
    period_inc = period_count + 1'b1;
    period_eff = (cfg.scan_period == '0) ? {{(WAIT_W-1){1'b0}}, 1'b1} : cfg.scan_period;
    if (cfg.enable) begin
      period_count_next = period_inc;
      if (period_inc >= period_eff) begin
        period_count_next = '0;
        trigger           = 1'b1;
      end
    end else begin
      period_count_next = '0;
      pending_next      = 1'b0;
    end

    wait_dec  = (wait_count != '0) ? wait_count - 1'b1 : wait_count;
    wait_done = (wait_dec == '0);

    case (phase)
      PH_IDLE: begin
        if (trigger) begin
          do_start  = 1'b1;
          start_col = 2'd0;
        end
      end
      PH_SETTLE: begin
        if (trigger) pending_next = 1'b1;
        wait_count_next = wait_dec;
        if (wait_done) do_check = 1'b1;
      end
      PH_RELEASE: begin
        if (trigger) pending_next = 1'b1;
        // rows above the current one; empty mask on the top row ends the column
        check_mask = 4'b1110 << row;
        if (!cfg.enable) begin
          do_check = 1'b1;
        end else begin
          wait_count_next = wait_dec;
          if (wait_done) begin
            if (rows[row]) do_check = 1'b1;
            else wait_count_next = cfg.release_poll;
          end
        end
      end
      PH_GAP: begin
        if (trigger) pending_next = 1'b1;
        wait_count_next = wait_dec;
        if (wait_done) begin
          if (column == 2'd3) begin
            phase_next  = PH_IDLE;
            column_next = 2'd0;
            row_next    = 2'd0;
            if (pending_next) begin
              pending_next = 1'b0;
              do_start     = 1'b1;
              start_col    = 2'd0;
            end
          end else begin
            do_start  = 1'b1;
            start_col = column + 2'd1;
          end
        end
      end
      default: ;
    endcase

    // lowest pulled-low row inside the mask
    low_rows = ~rows & check_mask;
    for (int r = 3; r >= 0; r--) begin
      if (low_rows[r]) begin
        hit     = 1'b1;
        hit_row = 2'(r);
      end
    end

    if (do_check) begin
      if (hit) begin
        key_idx         = {hit_row, column};
        res.key_valid   = 1'b1;
        res.key_code    = key_char(key_idx);
        res.key_index   = key_idx;
        row_next        = hit_row;
        phase_next      = PH_RELEASE;
        wait_count_next = {{(WAIT_W-1){1'b0}}, 1'b1};
      end else begin
        do_end = 1'b1;
      end
    end

    if (do_end) begin
      drive_next      = drive | (4'b0001 << column);
      phase_next      = PH_GAP;
      wait_count_next = cfg.column_gap;
    end

    if (do_start) begin
      column_next     = start_col;
      drive_next      = ~(4'b0001 << start_col);
      row_next        = 2'd0;
      phase_next      = PH_SETTLE;
      wait_count_next = cfg.settle_time;
    end

    res.column_drive = drive_next;
    res.scan_busy    = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      column       <= 2'd0;
      row          <= 2'd0;
      wait_count   <= '0;
      period_count <= '0;
      pending      <= 1'b0;
      drive        <= 4'hF;
    end else if (step) begin
      phase        <= phase_next;
      column       <= column_next;
      row          <= row_next;
      wait_count   <= wait_count_next;
      period_count <= period_count_next;
      pending      <= pending_next;
      drive        <= drive_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/matrix_keypad_scanner.sv
// top level of the 4x4 matrix keypad scanner: input register, step, report register
// depends on mks_pkg, mks_if, mks_regs and mks_core
//
// usage
//   sample : one transaction per 1 ms tick carrying the sampled row lines
//   report : one transaction per tick with the column drive to apply, the key
//            press seen this tick (key_valid, key_code, key_index) and scan_busy
//   apb    : five registers at byte addresses 0,4,8,12,16 (enable, scan period,
//            settle time, release poll, column gap); write only while idle
// timing
//   a sample taken at edge n sits in the input register, is stepped through the
//   scan state machine in the next cycle and shows up on report after edge n+1,
//   so its report transaction comes at edge n+2 at the earliest
//   throughput is one tick per cycle; the path from the input register through
//   the state update and key map into the report register sets that figure
// reset
//   synchronous, active high; scanner idle, all columns high, counters zero,
//   registers at their default values, both channel registers empty
// back-pressure
//   when report is stalled the finished transaction holds in the report register
//   and one more sample is still taken into the input register; sample.ready
//   drops only when both are full
`timescale 1ns / 1ps
`default_nettype none

module matrix_keypad_scanner (
  input  wire logic                       clk,
  input  wire logic                       rst,
  mks_in_if.sink                          sample,
  mks_out_if.source                       report,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mks_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mks_pkg::DATA_W-1:0] pwdata,
  output logic      [mks_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import mks_pkg::*;

  cfg_t       cfg;
  result_t    res;

  // input register
  logic       in_valid;
  logic [3:0] in_rows;
  // report register
  logic       out_valid;
  result_t    out_res;

  logic       step;

  mks_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // a tick steps the scanner when the report register is free or emptying
  assign step         = in_valid && (!out_valid || report.ready);
  assign sample.ready = !in_valid || step;

  mks_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .rows (in_rows),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  // row sample payload, no reset needed
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_rows <= sample.row_levels;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign report.valid        = out_valid;
  assign report.column_drive = out_res.column_drive;
  assign report.key_valid    = out_res.key_valid;
  assign report.key_code     = out_res.key_code;
  assign report.key_index    = out_res.key_index;
  assign report.scan_busy    = out_res.scan_busy;

  // a reported key always comes from a running scan with exactly one column low
  a_key_in_scan: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.key_valid |->
      out_res.scan_busy && ($countones(~out_res.column_drive) == 1))
    else $error("key reported outside a single-column scan");

  // no key means code and index read as zero
  a_no_key_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.key_valid |->
      (out_res.key_code == 7'd0) && (out_res.key_index == 4'd0))
    else $error("key fields nonzero without a key");

  // a held sample is not dropped while the report side stalls
  a_hold_sample: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !report.ready |=> in_valid && $stable(in_rows))
    else $error("pending sample lost during stall");

  // the key code always matches the key map entry of the reported index
  a_code_map: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.key_valid |-> out_res.key_code == key_char(out_res.key_index))
    else $error("key code does not match key index");

endmodule

`default_nettype wire
